/* src/arre_pkg.sv */
// shared types and constants for the ack/retry roll engine
// used by arre_prio_enc and ack_retry_roll_engine_core; no dependencies
package arre_pkg;

	localparam int NODES_DEF = 32;

	localparam int NODE_W  = 5;
	localparam int CTX_W   = 16;
	localparam int SEQ_W   = 16;
	localparam int TIME_W  = 32;
	localparam int CODE_W  = 8;
	localparam int ATT_W   = 4;
	localparam int WIN_W   = 24;
	localparam int OP_W    = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 64;

	localparam logic [WIN_W-1:0] ACK_TIMEOUT_RST   = WIN_W'(2000);
	localparam logic [ATT_W-1:0] RETRY_LIMIT_RST   = ATT_W'(3);
	localparam logic [WIN_W-1:0] RETRY_BACKOFF_RST = WIN_W'(1000);

	typedef enum logic [OP_W-1:0] {
		OP_HEARD  = 3'd0,
		OP_SUBMIT = 3'd1,
		OP_POLL   = 3'd2,
		OP_SENT   = 3'd3,
		OP_ACK    = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_SEND = 4'b0010,
		PH_WAIT = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_SEND    = 2'd1,
		ACT_RESOLVE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		OC_PENDING = 2'd0,
		OC_ROLLED  = 2'd1,
		OC_FAILED  = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		REG_ACK_TIMEOUT   = 2'd0,
		REG_RETRY_LIMIT   = 2'd1,
		REG_RETRY_BACKOFF = 2'd2
	} reg_idx_t;

	localparam logic [CODE_W-1:0] ACK_OK      = 8'd0;
	localparam logic [CODE_W-1:0] ACK_REJ_CTX = 8'd1;
	localparam logic [CODE_W-1:0] ACK_BUSY    = 8'd2;

	// lowest due-and-pending node
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
	} due_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic [NODE_W-1:0] due_node;
		logic              due_valid;
		logic [CODE_W-1:0] fail_code;
		logic              no_ack;
		outcome_t          outcome;
		logic [ATT_W-1:0]  attempt;
		logic [CTX_W-1:0]  out_ctx;
		logic [SEQ_W-1:0]  out_seq;
		logic [NODE_W-1:0] dest_node;
		logic              accepted;
	} result_t;

endpackage

/* src/arre_prio_enc.sv */
// lowest-index set-bit finder for the due report
// depends on arre_pkg
module arre_prio_enc #(
	parameter int WIDTH = arre_pkg::NODES_DEF
) (
	input  logic [WIDTH-1:0] req,
	output arre_pkg::due_t   due
);
	import arre_pkg::*;

	always_comb begin
		due = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (req[i]) begin
				due.valid = 1'b1;
				due.node  = NODE_W'(i);
			end
		end
	end

endmodule

/* src/ack_retry_roll_engine_core.sv */
// top level of the ack/retry roll engine: event stream in, one result word per event out
// depends on arre_pkg and arre_prio_enc
//
//   channel   dir  fields
//   s_*       in   tuser: operation[2:0]; tdata: node_index, ctx_id, seq, now_ms, ack_code
//   m_*       out  tuser: action[1:0]; tdata: accepted .. due_node (see port comments)
//   apb       in   ack_timeout_ms @0x0, retry_limit @0x4, retry_backoff_ms @0x8
//
// one word in, one word out per cycle while the result side does not stall
// an event passes the input register, then the result register
// the job state updates as an event leaves the input register for the result register
// a stalled result register holds the input register, and then s_tready drops
// reset restores all job state, masks and configuration registers at once, no sweep
module ack_retry_roll_engine_core #(
	parameter int NODES = arre_pkg::NODES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// event stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// node_index[4:0], ctx_id[20:5], seq[36:21], now_ms[68:37], ack_code[76:69], zero pad
	input  logic [arre_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation[2:0]
	input  logic [arre_pkg::OP_W-1:0]       s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// accepted[0], dest_node[5:1], out_seq[21:6], out_ctx[37:22], attempt[41:38],
	// outcome[43:42], no_ack[44], fail_code[52:45], due_valid[53], due_node[58:54], zero pad
	output logic [arre_pkg::M_TDATA_W-1:0]  m_tdata,
	// action[1:0]
	output logic [1:0]                      m_tuser,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [arre_pkg::ADDR_W-1:0]     paddr,
	input  logic [arre_pkg::DATA_W-1:0]     pwdata,
	output logic [arre_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import arre_pkg::*;

	// configuration registers
	logic [WIN_W-1:0] ack_timeout_q;
	logic [ATT_W-1:0] retry_limit_q;
	logic [WIN_W-1:0] retry_backoff_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// input register
	logic              s1_valid;
	logic [OP_W-1:0]   s1_op;
	logic [NODE_W-1:0] s1_node;
	logic [CTX_W-1:0]  s1_ctx;
	logic [SEQ_W-1:0]  s1_seq;
	logic [TIME_W-1:0] s1_now;
	logic [CODE_W-1:0] s1_code;

	// job state
	phase_t            phase_q,   phase_n;
	logic [NODES-1:0]  pending_q, pending_n;
	logic [NODES-1:0]  due_q,     due_n;
	logic [NODE_W-1:0] job_node_q, job_node_n;
	logic [CTX_W-1:0]  job_ctx_q,  job_ctx_n;
	logic [SEQ_W-1:0]  job_seq_q,  job_seq_n;
	logic [ATT_W-1:0]  attempt_q,  attempt_n;
	outcome_t          outcome_q,  outcome_n;
	logic              no_ack_q,   no_ack_n;
	logic [CODE_W-1:0] fail_code_q, fail_code_n;
	logic [TIME_W-1:0] win_start_q, win_start_n;

	// result register
	logic    m_valid_q;
	result_t m_res_q;
	action_t m_act_q;
	result_t res_n;
	result_t res_out;
	action_t act_n;

	// handshakes and datapath helpers
	logic              s_accept;
	logic              adv;
	logic [NODES-1:0]  evt_bit;
	logic [NODES-1:0]  job_bit;
	logic [TIME_W-1:0] win_len;
	logic [TIME_W-1:0] elapsed;
	logic              win_open;
	due_t              due_rpt;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q   <= ACK_TIMEOUT_RST;
			retry_limit_q   <= RETRY_LIMIT_RST;
			retry_backoff_q <= RETRY_BACKOFF_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ACK_TIMEOUT:   ack_timeout_q   <= pwdata[WIN_W-1:0];
				REG_RETRY_LIMIT:   retry_limit_q   <= pwdata[ATT_W-1:0];
				REG_RETRY_BACKOFF: retry_backoff_q <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_ACK_TIMEOUT:   prdata = DATA_W'(ack_timeout_q);
			REG_RETRY_LIMIT:   prdata = DATA_W'(retry_limit_q);
			REG_RETRY_BACKOFF: prdata = DATA_W'(retry_backoff_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- stream control ----------------
	// the compute stage fires when the result register is free or being drained
	assign adv      = s1_valid && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid || adv;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_accept) begin
			s1_valid <= 1'b1;
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	// event payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_accept) begin
			s1_op   <= s_tuser;
			s1_node <= s_tdata[4:0];
			s1_ctx  <= s_tdata[20:5];
			s1_seq  <= s_tdata[36:21];
			s1_now  <= s_tdata[68:37];
			s1_code <= s_tdata[76:69];
		end
	end

	// ---------------- event logic ----------------
	// unknown nodes (index NODES or above) have no mask bit
	assign evt_bit = (32'(s1_node) < NODES) ? (NODES'(1) << s1_node) : '0;
	assign job_bit = (32'(job_node_q) < NODES) ? (NODES'(1) << job_node_q) : '0;

	// ack window, wrap-safe: a negative elapsed time counts as still open
	assign win_len  = TIME_W'(ack_timeout_q)
	                + ((attempt_q != '0) ? TIME_W'(retry_backoff_q) : '0);
	assign elapsed  = s1_now - win_start_q;
	assign win_open = elapsed[TIME_W-1] || (elapsed < win_len);

	always_comb begin
		phase_n     = phase_q;
		pending_n   = pending_q;
		due_n       = due_q;
		job_node_n  = job_node_q;
		job_ctx_n   = job_ctx_q;
		job_seq_n   = job_seq_q;
		attempt_n   = attempt_q;
		outcome_n   = outcome_q;
		no_ack_n    = no_ack_q;
		fail_code_n = fail_code_q;
		win_start_n = win_start_q;
		res_n       = '0;
		act_n       = ACT_NONE;

		unique case (s1_op)
			OP_HEARD: begin
				// a heard from the node of the running job is ignored
				if ((pending_q & evt_bit) != '0
				    && !(phase_q != PH_IDLE && job_node_q == s1_node)) begin
					due_n = due_q | evt_bit;
				end
			end
			OP_SUBMIT: begin
				if (phase_q == PH_IDLE && (pending_q & evt_bit) != '0 && s1_ctx != '0) begin
					due_n          = due_q & ~evt_bit;
					job_node_n     = s1_node;
					job_ctx_n      = s1_ctx;
					job_seq_n      = s1_seq;
					attempt_n      = '0;
					outcome_n      = OC_PENDING;
					no_ack_n       = 1'b0;
					fail_code_n    = '0;
					win_start_n    = s1_now;
					phase_n        = PH_SEND;
					res_n.accepted = 1'b1;
				end
			end
			OP_POLL: begin
				// window expiry first: retry or give up with no ack
				if (phase_q == PH_WAIT && !win_open) begin
					if (attempt_q >= retry_limit_q) begin
						outcome_n   = OC_FAILED;
						no_ack_n    = 1'b1;
						fail_code_n = '0;
						phase_n     = PH_DONE;
					end else begin
						attempt_n = attempt_q + ATT_W'(1);
						phase_n   = PH_SEND;
					end
				end
				// then report what the job needs now
				if (phase_n == PH_SEND || phase_n == PH_DONE) begin
					res_n.dest_node = job_node_q;
					res_n.out_seq   = job_seq_q;
					res_n.out_ctx   = job_ctx_q;
					res_n.attempt   = attempt_n;
				end
				if (phase_n == PH_SEND) begin
					act_n = ACT_SEND;
				end else if (phase_n == PH_DONE) begin
					act_n           = ACT_RESOLVE;
					res_n.outcome   = outcome_n;
					res_n.no_ack    = no_ack_n;
					res_n.fail_code = fail_code_n;
					phase_n         = PH_IDLE;
				end
			end
			OP_SENT: begin
				if (phase_q == PH_SEND) begin
					win_start_n = s1_now;
					phase_n     = PH_WAIT;
				end
			end
			OP_ACK: begin
				if (phase_q == PH_WAIT && s1_node == job_node_q && s1_seq == job_seq_q) begin
					res_n.accepted = 1'b1;
					case (s1_code) inside
						ACK_OK, ACK_REJ_CTX: begin
							// roll: node leaves both masks, ack carries the new context
							pending_n = pending_q & ~job_bit;
							due_n     = due_q & ~job_bit;
							job_ctx_n = s1_ctx;
							outcome_n = OC_ROLLED;
							phase_n   = PH_DONE;
						end
						ACK_BUSY: begin
							// reopen the window, no attempt spent
							win_start_n = s1_now;
						end
						default: begin
							outcome_n   = OC_FAILED;
							no_ack_n    = 1'b0;
							fail_code_n = s1_code;
							phase_n     = PH_DONE;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// due report is taken after this event's update
	arre_prio_enc #(
		.WIDTH (NODES)
	) u_due_enc (
		.req (due_n & pending_n),
		.due (due_rpt)
	);

	// result word with the due report merged in
	always_comb begin
		res_out           = res_n;
		res_out.due_valid = due_rpt.valid;
		res_out.due_node  = due_rpt.node;
	end

	// ---------------- state and result registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pending_q   <= '1;
			due_q       <= '0;
			job_node_q  <= '0;
			job_ctx_q   <= '0;
			job_seq_q   <= '0;
			attempt_q   <= '0;
			outcome_q   <= OC_PENDING;
			no_ack_q    <= 1'b0;
			fail_code_q <= '0;
			win_start_q <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			pending_q   <= pending_n;
			due_q       <= due_n;
			job_node_q  <= job_node_n;
			job_ctx_q   <= job_ctx_n;
			job_seq_q   <= job_seq_n;
			attempt_q   <= attempt_n;
			outcome_q   <= outcome_n;
			no_ack_q    <= no_ack_n;
			fail_code_q <= fail_code_n;
			win_start_q <= win_start_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_res_q <= res_out;
			m_act_q <= act_n;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_TDATA_W'(m_res_q);
	assign m_tuser  = m_act_q;

	// ---------------- assertions ----------------
	// a node can only be due while it is still pending
	a_due_in_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(due_q & ~pending_q) == '0)
		else $error("due node outside pending mask");

	// a reported due node is a real table entry
	a_due_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_res_q.due_valid |-> 32'(m_res_q.due_node) < NODES)
		else $error("due node beyond table");

	// a taken submit starts the job in send-due
	a_submit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && s1_op == OP_SUBMIT && res_n.accepted |=> phase_q == PH_SEND)
		else $error("accepted submit did not open a job");

	// a resolve report always frees the engine
	a_resolve_idles: assert property (@(posedge clk) disable iff (!arst_n)
		adv && act_n == ACT_RESOLVE |=> phase_q == PH_IDLE)
		else $error("resolve left the engine busy");

endmodule

/* bench/tb_ack_retry_roll_engine_core.sv */
`timescale 1ns / 1ps
// self-checking bench for ack_retry_roll_engine_core: directed event script, then random phases
// depends on arre_pkg and the engine RTL; predicts every result word and checks it field by field

module tb_ack_retry_roll_engine_core;
	import arre_pkg::*;

	localparam int NODES        = NODES_DEF;
	localparam int LATENCY      = 2;
	localparam int HOLD_CYCLES  = 48;
	localparam int STALL_LIMIT  = 4000;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 153;
	// operation codes past ack do nothing but report the due node
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	// one event word, packed as on s_tdata (node_index in the lowest bits)
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] now;
		logic [SEQ_W-1:0]  seq;
		logic [CTX_W-1:0]  ctx;
		logic [NODE_W-1:0] node;
	} evt_t;

	// one result word together with its action from m_tuser
	typedef struct packed {
		action_t act;
		result_t res;
	} outword_t;

	// directed script row; a typed row carries its own expected word
	typedef struct {
		logic [OP_W-1:0] op;
		evt_t            e;
		bit              typed;
		outword_t        want;
	} drow_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [1:0]            m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	// predicted engine state, kept in step with every accepted event word
	phase_t                cur_phase;
	logic [31:0]           roll_pending;
	logic [31:0]           heard_due;
	logic [NODE_W-1:0]     j_node;
	logic [CTX_W-1:0]      j_ctx;
	logic [SEQ_W-1:0]      j_seq;
	logic [ATT_W-1:0]      j_tries;
	outcome_t              j_result;
	logic                  j_timed_out;
	logic [CODE_W-1:0]     j_code;
	logic [TIME_W-1:0]     win_start;
	logic [WIN_W-1:0]      cfg_timeout;
	logic [ATT_W-1:0]      cfg_limit;
	logic [WIN_W-1:0]      cfg_backoff;

	outword_t              want_words[$];
	drow_t                 script[$];
	outword_t              predicted;
	outword_t              got;
	outword_t              oldest;
	outword_t              typed_want;
	bit                    typed_next;
	bit                    tx_gaps;
	bit                    rx_gaps;
	bit                    hold_req;
	int                    mismatches;
	int                    idle_cycles;

	ack_retry_roll_engine_core #(.NODES(NODES)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor: next state and result word of one accepted event
	// ------------------------------------------------------------------
	task automatic predict_roll_event(input logic [OP_W-1:0] op, input evt_t e,
			output outword_t w);
		logic [31:0] nbit;
		logic [31:0] jbit;
		logic [31:0] window;
		logic [31:0] elapsed;
		logic [31:0] ready;
		int i;
		w = '0;
		nbit = (e.node < NODES) ? (32'd1 << e.node) : 32'd0;
		jbit = (j_node < NODES) ? (32'd1 << j_node) : 32'd0;
		case (op)
		OP_HEARD: begin
			// the node of a running job is not marked due
			if ((roll_pending & nbit) != 0 && !(cur_phase != PH_IDLE && j_node == e.node))
				heard_due |= nbit;
		end
		OP_SUBMIT: begin
			if (cur_phase == PH_IDLE && (roll_pending & nbit) != 0 && e.ctx != 0) begin
				heard_due &= ~nbit;
				j_node = e.node;
				j_ctx = e.ctx;
				j_seq = e.seq;
				j_tries = '0;
				j_result = OC_PENDING;
				j_timed_out = 1'b0;
				j_code = '0;
				win_start = e.now;
				cur_phase = PH_SEND;
				w.res.accepted = 1'b1;
			end
		end
		OP_POLL: begin
			if (cur_phase == PH_WAIT) begin
				// wrap-safe window: a negative elapsed time keeps it open
				window = 32'(cfg_timeout) + ((j_tries != 0) ? 32'(cfg_backoff) : 32'd0);
				elapsed = e.now - win_start;
				if (!elapsed[31] && elapsed >= window) begin
					if (j_tries >= cfg_limit) begin
						j_result = OC_FAILED;
						j_timed_out = 1'b1;
						j_code = '0;
						cur_phase = PH_DONE;
					end else begin
						j_tries = j_tries + 1'b1;
						cur_phase = PH_SEND;
					end
				end
			end
			if (cur_phase == PH_SEND || cur_phase == PH_DONE) begin
				w.act = (cur_phase == PH_SEND) ? ACT_SEND : ACT_RESOLVE;
				w.res.dest_node = j_node;
				w.res.out_seq = j_seq;
				w.res.out_ctx = j_ctx;
				w.res.attempt = j_tries;
			end
			if (cur_phase == PH_DONE) begin
				w.res.outcome = j_result;
				w.res.no_ack = j_timed_out;
				w.res.fail_code = j_code;
				cur_phase = PH_IDLE;
			end
		end
		OP_SENT: begin
			if (cur_phase == PH_SEND) begin
				win_start = e.now;
				cur_phase = PH_WAIT;
			end
		end
		OP_ACK: begin
			if (cur_phase == PH_WAIT && e.node == j_node && e.seq == j_seq) begin
				w.res.accepted = 1'b1;
				if (e.code == ACK_OK || e.code == ACK_REJ_CTX) begin
					roll_pending &= ~jbit;
					heard_due &= ~jbit;
					j_ctx = e.ctx;
					j_result = OC_ROLLED;
					cur_phase = PH_DONE;
				end else if (e.code == ACK_BUSY) begin
					win_start = e.now;
				end else begin
					j_result = OC_FAILED;
					j_timed_out = 1'b0;
					j_code = e.code;
					cur_phase = PH_DONE;
				end
			end
		end
		default: ;
		endcase
		ready = heard_due & roll_pending;
		for (i = NODES - 1; i >= 0; i--) begin
			if (ready[i]) begin
				w.res.due_valid = 1'b1;
				w.res.due_node = NODE_W'(i);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic evt_t ev(input int unsigned node, input int unsigned ctx,
			input int unsigned seq, input int unsigned now, input int unsigned code);
		ev.node = NODE_W'(node);
		ev.ctx  = CTX_W'(ctx);
		ev.seq  = SEQ_W'(seq);
		ev.now  = TIME_W'(now);
		ev.code = CODE_W'(code);
	endfunction

	// result word with no job fields and no action
	function automatic outword_t quiet(input logic acc, input logic dv,
			input logic [NODE_W-1:0] dn);
		quiet = '0;
		quiet.act = ACT_NONE;
		quiet.res.accepted = acc;
		quiet.res.due_valid = dv;
		quiet.res.due_node = dn;
	endfunction

	// some node still to roll, or any node once all have rolled
	function automatic logic [NODE_W-1:0] pending_node();
		int start;
		int k;
		pending_node = NODE_W'($urandom);
		start = $urandom_range(0, NODES - 1);
		for (k = NODES - 1; k >= 0; k--)
			if (roll_pending[(start + k) % NODES])
				pending_node = NODE_W'((start + k) % NODES);
	endfunction

	// random event shaped by the predicted phase, so that most jobs run to
	// their end; the rest is fully random noise
	task automatic make_event(output logic [OP_W-1:0] op, output evt_t e);
		int unsigned pick;
		logic [31:0] window;
		e.node = NODE_W'($urandom);
		e.ctx  = CTX_W'($urandom);
		e.seq  = SEQ_W'($urandom);
		e.now  = TIME_W'($urandom);
		e.code = CODE_W'($urandom);
		op = OP_W'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick >= 15) begin
			case (cur_phase)
			PH_IDLE: begin
				if (pick < 60) begin
					op = OP_SUBMIT;
					e.node = pending_node();
					if (pick < 19)
						e.ctx = '0;
				end else if (pick < 85) begin
					op = OP_HEARD;
					if (pick < 75)
						e.node = pending_node();
				end else begin
					op = OP_POLL;
				end
			end
			PH_SEND: begin
				if (pick < 60) begin
					op = OP_SENT;
				end else if (pick < 88) begin
					op = OP_POLL;
				end else begin
					op = OP_HEARD;
					e.node = j_node;
				end
			end
			PH_WAIT: begin
				window = 32'(cfg_timeout) + ((j_tries != 0) ? 32'(cfg_backoff) : 32'd0);
				if (pick < 53) begin
					op = OP_ACK;
					e.node = j_node;
					e.seq = j_seq;
					case ($urandom_range(0, 15))
					0: e.code = ACK_OK;
					1: e.code = ACK_REJ_CTX;
					2, 3, 4, 5, 6: e.code = ACK_BUSY;
					7: e.seq = e.seq ^ SEQ_W'(1 << $urandom_range(0, SEQ_W - 1));
					8: e.node = e.node ^ NODE_W'(1 << $urandom_range(0, NODE_W - 1));
					default: ;
					endcase
				end else begin
					// poll right at, just inside, past or before the window edge
					op = OP_POLL;
					case ($urandom_range(0, 4))
					0: e.now = win_start + window - 1;
					1: e.now = win_start + window;
					2: e.now = win_start + window + $urandom_range(0, 4096);
					3: e.now = win_start + $urandom_range(0, window);
					default: e.now = win_start - $urandom_range(1, 1 << 20);
					endcase
				end
			end
			PH_DONE: begin
				if (pick < 85) begin
					op = OP_POLL;
				end else begin
					op = OP_HEARD;
					e.node = j_node;
				end
			end
			default: ;
			endcase
		end
	endtask

	// offer one event word; random words are drawn only once the previous
	// word has gone through the predictor
	task automatic send_event(input bit gen, input logic [OP_W-1:0] op_in, input evt_t e_in,
			input bit typed, input outword_t want);
		logic [OP_W-1:0] op;
		evt_t e;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		op = op_in;
		e = e_in;
		if (gen)
			make_event(op, e);
		typed_next = typed;
		typed_want = want;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= S_TDATA_W'(e);
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	// stop offering and let every expected word come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (want_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// register write followed by a read-back of the same register
	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] kept;
		case (idx)
		REG_ACK_TIMEOUT: begin
			cfg_timeout = value[WIN_W-1:0];
			kept = DATA_W'(cfg_timeout);
		end
		REG_RETRY_LIMIT: begin
			cfg_limit = value[ATT_W-1:0];
			kept = DATA_W'(cfg_limit);
		end
		default: begin
			cfg_backoff = value[WIN_W-1:0];
			kept = DATA_W'(cfg_backoff);
		end
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== kept) begin
			$display("%0t: register %0d read-back mismatch, expected %0h, actual %0h",
				$time, idx, kept, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] actual);
		if (actual !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, actual);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// monitors
	// ------------------------------------------------------------------

	// every accepted event word goes through the predictor, in order
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_roll_event(s_tuser, evt_t'(s_tdata[$bits(evt_t)-1:0]), predicted);
			want_words.push_back(typed_next ? typed_want : predicted);
		end
	end

	// every accepted result word is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.act = action_t'(m_tuser);
			got.res = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (want_words.size() == 0) begin
				$display("%0t: result word with nothing expected, expected none, actual %0h",
					$time, got);
				mismatches++;
			end else begin
				oldest = want_words.pop_front();
				check_field("action", oldest.act, got.act);
				check_field("accepted", oldest.res.accepted, got.res.accepted);
				check_field("dest_node", oldest.res.dest_node, got.res.dest_node);
				check_field("out_seq", oldest.res.out_seq, got.res.out_seq);
				check_field("out_ctx", oldest.res.out_ctx, got.res.out_ctx);
				check_field("attempt", oldest.res.attempt, got.res.attempt);
				check_field("outcome", oldest.res.outcome, got.res.outcome);
				check_field("no_ack", oldest.res.no_ack, got.res.no_ack);
				check_field("fail_code", oldest.res.fail_code, got.res.fail_code);
				check_field("due_valid", oldest.res.due_valid, got.res.due_valid);
				check_field("due_node", oldest.res.due_node, got.res.due_node);
			end
		end
	end

	// watchdog: too many cycles with no word moving on either stream
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// result side: random stall bursts, and one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int p;
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		typed_next = 1'b0;
		typed_want = '0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		// state right after reset
		cur_phase = PH_IDLE;
		roll_pending = (NODES >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NODES) - 1);
		heard_due = '0;
		j_node = '0;
		j_ctx = '0;
		j_seq = '0;
		j_tries = '0;
		j_result = OC_PENDING;
		j_timed_out = 1'b0;
		j_code = '0;
		win_start = '0;
		cfg_timeout = ACK_TIMEOUT_RST;
		cfg_limit = RETRY_LIMIT_RST;
		cfg_backoff = RETRY_BACKOFF_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed script, run with the reset configuration
		// (timeout 2000, three retries, backoff 1000)
		// poll right after reset: nothing to do, nothing due
		script.push_back('{OP_POLL,   ev(0, 0, 0, 0, 0), 1'b1, quiet(1'b0, 1'b0, 5'd0)});
		script.push_back('{OP_HEARD,  ev(0, 0, 0, 0, 0), 1'b1, quiet(1'b0, 1'b1, 5'd0)});
		script.push_back('{OP_HEARD,  ev(31, 0, 0, 0, 0), 1'b0, '0});
		// zero context is refused
		script.push_back('{OP_SUBMIT, ev(0, 0, 5, 10, 0), 1'b1, quiet(1'b0, 1'b1, 5'd0)});
		// all-ones job, node 0 leaves the due set
		script.push_back('{OP_SUBMIT, ev(0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF00, 0), 1'b1,
			quiet(1'b1, 1'b1, 5'd31)});
		// refused while busy, and the job's own node is not marked due
		script.push_back('{OP_SUBMIT, ev(1, 1, 1, 0, 0), 1'b0, '0});
		script.push_back('{OP_HEARD,  ev(0, 0, 0, 0, 0), 1'b0, '0});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 32'hFFFF_FF00, 0), 1'b0, '0});
		// ack before the send is not taken
		script.push_back('{OP_ACK,    ev(0, 0, 16'hFFFF, 0, ACK_OK), 1'b0, '0});
		script.push_back('{OP_SENT,   ev(0, 0, 0, 32'hFFFF_FF00, 0), 1'b0, '0});
		// window across the 32-bit wrap, then a time before the window start
		script.push_back('{OP_POLL,   ev(0, 0, 0, 32'h0000_0100, 0), 1'b0, '0});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 32'hFFFF_FE00, 0), 1'b0, '0});
		// wrong sequence, wrong node
		script.push_back('{OP_ACK,    ev(0, 0, 0, 0, ACK_OK), 1'b0, '0});
		script.push_back('{OP_ACK,    ev(1, 0, 16'hFFFF, 0, ACK_OK), 1'b0, '0});
		// busy ack reopens the window at 1000
		script.push_back('{OP_ACK,    ev(0, 0, 16'hFFFF, 1000, ACK_BUSY), 1'b0, '0});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 2999, 0), 1'b0, '0});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 3000, 0), 1'b0, '0});
		script.push_back('{OP_SENT,   ev(0, 0, 0, 5000, 0), 1'b0, '0});
		// retry window includes the backoff
		script.push_back('{OP_POLL,   ev(0, 0, 0, 7999, 0), 1'b0, '0});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 8000, 0), 1'b0, '0});
		script.push_back('{OP_SENT,   ev(0, 0, 0, 9000, 0), 1'b0, '0});
		// rejected-context ack rolls the node to the new context
		script.push_back('{OP_ACK,    ev(0, 16'h1234, 16'hFFFF, 9100, ACK_REJ_CTX), 1'b0, '0});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 9200, 0), 1'b0, '0});
		// node 31 job, nothing left due
		script.push_back('{OP_SUBMIT, ev(31, 1, 0, 0, 0), 1'b1, quiet(1'b1, 1'b0, 5'd0)});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 0, 0), 1'b0, '0});
		script.push_back('{OP_SENT,   ev(0, 0, 0, 0, 0), 1'b0, '0});
		// failure code ends the job, reported by the next poll
		script.push_back('{OP_ACK,    ev(31, 0, 0, 0, 8'hFF), 1'b1, quiet(1'b1, 1'b0, 5'd0)});
		script.push_back('{OP_POLL,   ev(0, 0, 0, 0, 0), 1'b0, '0});
		script.push_back('{OP_UNUSED, ev(31, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF), 1'b1,
			quiet(1'b0, 1'b0, 5'd0)});
		foreach (script[r])
			send_event(1'b0, script[r].op, script[r].e, script[r].typed, script[r].want);

		// random phases: reset values, all-zero, all-ones, fully random, small random
		for (p = 0; p < RAND_PHASES; p++) begin
			if (p > 0) begin
				drain();
				case (p)
				1: begin
					cfg_write(REG_ACK_TIMEOUT, 32'h0000_0000);
					cfg_write(REG_RETRY_LIMIT, 32'h0000_0000);
					cfg_write(REG_RETRY_BACKOFF, 32'h0000_0000);
				end
				2: begin
					cfg_write(REG_ACK_TIMEOUT, 32'hFFFF_FFFF);
					cfg_write(REG_RETRY_LIMIT, 32'hFFFF_FFFF);
					cfg_write(REG_RETRY_BACKOFF, 32'hFFFF_FFFF);
				end
				3: begin
					cfg_write(REG_ACK_TIMEOUT, $urandom);
					cfg_write(REG_RETRY_LIMIT, $urandom);
					cfg_write(REG_RETRY_BACKOFF, $urandom);
				end
				default: begin
					cfg_write(REG_ACK_TIMEOUT, {8'($urandom), 24'($urandom_range(0, 3000))});
					cfg_write(REG_RETRY_LIMIT, $urandom);
					cfg_write(REG_RETRY_BACKOFF, {8'($urandom), 24'($urandom_range(0, 3000))});
				end
				endcase
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// idle bursts switch on and off in stretches; none in the last phase
				if (n % 40 == 0) begin
					tx_gaps = (p != RAND_PHASES - 1) && ($urandom_range(0, 2) != 0);
					rx_gaps = (p != RAND_PHASES - 1) && ($urandom_range(0, 2) != 0);
				end
				// long result-side hold-off while words keep coming, so the input stalls
				if (p == 3 && n == 50)
					hold_req = 1'b1;
				// sender pause until every expected word is out
				if (p == 3 && n == 100)
					drain();
				send_event(1'b1, OP_UNUSED, '0, 1'b0, '0);
			end
		end

		drain();
		if (mismatches == 0 && want_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
